// ===== hdl/gbi_pkg.sv =====
// ----------------------------------------------------------------------------
// gbi_pkg: shared types and constants for the grid bilinear interpolator
// Field widths, item codes, status codes and register indexes.
// ----------------------------------------------------------------------------
package gbi_pkg;

    localparam int SAMPLE_W = 16;   // grid sample width
    localparam int CORD_W   = 17;   // query coordinate width
    localparam int CELL_W   = 8;    // write address field width
    localparam int ELEV_W   = 24;   // result elevation width
    localparam int STAT_W   = 2;    // result status width
    localparam int CFG_W    = 9;    // config register width
    localparam int CFG_IDX_W = 1;

    // item codes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_OOB  = 2'd1;
    localparam logic [STAT_W-1:0] ST_VOID = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b1;
    localparam logic [CFG_W-1:0]     CFG_DIM_RESET = 9'd256;

    // sample value that marks a cell without data
    localparam logic [SAMPLE_W-1:0] NO_DATA = 16'h8000;

    // per-query control that travels with the memory read
    typedef struct packed {
        logic oob;  // coordinate outside the grid
        logic px;   // parity of the left column
        logic py;   // parity of the upper row
    } t_qctl;

endpackage

// ===== hdl/gbi_item_if.sv =====
// ----------------------------------------------------------------------------
// gbi_item_if: input channel of the interpolator
// One beat is a cell write or a query.
// ----------------------------------------------------------------------------
interface gbi_item_if
    import gbi_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic        [CELL_W-1:0]   cell_col;
    logic        [CELL_W-1:0]   cell_row;
    logic signed [SAMPLE_W-1:0] cell_value;
    logic signed [CORD_W-1:0]   x_pos;
    logic signed [CORD_W-1:0]   y_pos;

    modport source (
        output valid, mode, cell_col, cell_row, cell_value, x_pos, y_pos,
        input  ready
    );
    modport sink (
        input  valid, mode, cell_col, cell_row, cell_value, x_pos, y_pos,
        output ready
    );
endinterface

// ===== hdl/gbi_result_if.sv =====
// ----------------------------------------------------------------------------
// gbi_result_if: result channel of the interpolator
// One beat per query: elevation and status.
// ----------------------------------------------------------------------------
interface gbi_result_if
    import gbi_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [ELEV_W-1:0] elevation;
    logic        [STAT_W-1:0] status;

    modport source (
        output valid, elevation, status,
        input  ready
    );
    modport sink (
        input  valid, elevation, status,
        output ready
    );
endinterface

// ===== hdl/gbi_bank_ram.sv =====
// ----------------------------------------------------------------------------
// gbi_bank_ram: one parity bank of the elevation grid
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module gbi_bank_ram
    import gbi_pkg::*;
#(
    parameter int ADDR_W = 14
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [ADDR_W-1:0]   i_waddr,
    input  logic [SAMPLE_W-1:0] i_wdata,
    input  logic                i_re,
    input  logic [ADDR_W-1:0]   i_raddr,
    output logic [SAMPLE_W-1:0] o_rdata
);

    logic [SAMPLE_W-1:0] r_mem [2**ADDR_W];
    logic [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/gbi_blend.sv =====
// ----------------------------------------------------------------------------
// gbi_blend: blend pipeline of the interpolator
// Corner select and void check, horizontal blend, vertical blend with floor
// shift and saturation, output register. Stages advance independently.
// ----------------------------------------------------------------------------
module gbi_blend
    import gbi_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,      // query accepted this edge
    input  t_qctl                i_ctl,
    input  logic [FRAC_BITS-1:0] i_fx,
    input  logic [FRAC_BITS-1:0] i_fy,
    input  logic [SAMPLE_W-1:0]  i_corner [4], // bank read data, aligned with stage 1
    output logic                 o_take_en,   // stage 1 can load
    gbi_result_if.source         o_result
);

    localparam int WW = FRAC_BITS + 1;             // weight width
    localparam int AW = SAMPLE_W + WW + 1;         // row blend width
    localparam int SW = AW + WW + 1;               // full sum width
    localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;
    localparam longint ERR_FULL = -64'sd9999 * (64'sd1 <<< FRAC_BITS);
    localparam logic signed [ELEV_W-1:0] ELEV_MAX = 24'sh7FFFFF;
    localparam logic signed [ELEV_W-1:0] ELEV_MIN = 24'sh800000;
    localparam logic signed [ELEV_W-1:0] ERR_ELEV =
        (ERR_FULL < -64'sd8388608) ? ELEV_MIN : ELEV_W'(ERR_FULL);
    localparam logic signed [SW-1:0] SAT_HI = {{(SW-ELEV_W){1'b0}}, ELEV_MAX};
    localparam logic signed [SW-1:0] SAT_LO = {{(SW-ELEV_W){1'b1}}, ELEV_MIN};

    // stage enables
    logic en1, en2, en3;

    // stage 1: control beside the memory read
    logic                 r_s1_valid;
    t_qctl                r_s1_ctl;
    logic [FRAC_BITS-1:0] r_s1_fx;
    logic [FRAC_BITS-1:0] r_s1_fy;

    // stage 2: row blends
    logic                    r_s2_valid;
    logic [STAT_W-1:0]       r_s2_status;
    logic signed [AW-1:0]    r_s2_a;
    logic signed [AW-1:0]    r_s2_b;
    logic [FRAC_BITS-1:0]    r_s2_fy;
    logic [STAT_W-1:0]       n_s2_status;
    logic signed [AW-1:0]    n_s2_a;
    logic signed [AW-1:0]    n_s2_b;

    // output register
    logic                     r_o_valid;
    logic signed [ELEV_W-1:0] r_o_elev;
    logic [STAT_W-1:0]        r_o_status;
    logic signed [ELEV_W-1:0] n_o_elev;

    logic signed [SAMPLE_W-1:0] q1, q2, q3, q4;
    logic                       corner_void;
    logic [WW-1:0]              wx0, wx1, wy0, wy1;
    logic signed [SW-1:0]       sum;
    logic signed [SW-1:0]       shifted;

    assign en3       = !r_o_valid || o_result.ready;
    assign en2       = !r_s2_valid || en3;
    assign en1       = !r_s1_valid || en2;
    assign o_take_en = en1;

    // stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en1) begin
            r_s1_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_ctl <= i_ctl;
            r_s1_fx  <= i_fx;
            r_s1_fy  <= i_fy;
        end
    end

    // corner select by parity, void check, horizontal blend
    always_comb begin
        q1 = $signed(i_corner[{r_s1_ctl.py, r_s1_ctl.px}]);
        q2 = $signed(i_corner[{r_s1_ctl.py, ~r_s1_ctl.px}]);
        q3 = $signed(i_corner[{~r_s1_ctl.py, r_s1_ctl.px}]);
        q4 = $signed(i_corner[{~r_s1_ctl.py, ~r_s1_ctl.px}]);
        corner_void = (q1 == NO_DATA) || (q2 == NO_DATA) ||
                      (q3 == NO_DATA) || (q4 == NO_DATA);
        wx1 = {1'b0, r_s1_fx};
        wx0 = ONE - wx1;
        n_s2_a = AW'(q1) * AW'($signed({1'b0, wx0})) +
                 AW'(q2) * AW'($signed({1'b0, wx1}));
        n_s2_b = AW'(q3) * AW'($signed({1'b0, wx0})) +
                 AW'(q4) * AW'($signed({1'b0, wx1}));
        if (r_s1_ctl.oob) begin
            n_s2_status = ST_OOB;
        end else if (corner_void) begin
            n_s2_status = ST_VOID;
        end else begin
            n_s2_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_status <= n_s2_status;
            r_s2_a      <= n_s2_a;
            r_s2_b      <= n_s2_b;
            r_s2_fy     <= r_s1_fy;
        end
    end

    // vertical blend, floor shift, saturate
    always_comb begin
        wy1     = {1'b0, r_s2_fy};
        wy0     = ONE - wy1;
        sum     = SW'(r_s2_a) * SW'($signed({1'b0, wy0})) +
                  SW'(r_s2_b) * SW'($signed({1'b0, wy1}));
        shifted = sum >>> FRAC_BITS;
        if (r_s2_status != ST_OK) begin
            n_o_elev = ERR_ELEV;
        end else if (shifted > SAT_HI) begin
            n_o_elev = ELEV_MAX;
        end else if (shifted < SAT_LO) begin
            n_o_elev = ELEV_MIN;
        end else begin
            n_o_elev = shifted[ELEV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en3) begin
            r_o_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_o_elev   <= n_o_elev;
            r_o_status <= r_s2_status;
        end
    end

    assign o_result.valid     = r_o_valid;
    assign o_result.elevation = r_o_elev;
    assign o_result.status    = r_o_status;

endmodule

// ===== hdl/grid_bilinear_interpolator.sv =====
// Throughput: one beat per cycle, writes and queries alike, when the result
// side keeps up; the four corners are read together from four parity banks.
// Pipeline: three register stages; a query result passes stage 1, stage 2
// and the output register in turn; a write is visible to a query accepted in
// the next cycle. Writes give no beat.
// Reset: pipeline emptied, r_cols and r_rows set to 256; grid contents
// are undefined until written (no clearing pass).
// ----------------------------------------------------------------------------
// grid_bilinear_interpolator: banked elevation grid with bilinear queries
// Address generation, bounds check, four-bank grid memory, blend pipeline.
// ----------------------------------------------------------------------------
module grid_bilinear_interpolator
    import gbi_pkg::*;
#(
    parameter int MAX_COLS  = 256,
    parameter int MAX_ROWS  = 256,
    parameter int FRAC_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    gbi_item_if.sink             i_item,
    gbi_result_if.source         o_result
);

    // The grid is split by row and column parity into four banks, so the
    // 2x2 neighborhood of any query touches each bank exactly once.
    // Half-index widths: bank address bits per dimension.
    localparam int HCW = ($clog2((MAX_COLS + 1) / 2) > 0) ? $clog2((MAX_COLS + 1) / 2) : 1;
    localparam int HRW = ($clog2((MAX_ROWS + 1) / 2) > 0) ? $clog2((MAX_ROWS + 1) / 2) : 1;
    localparam int CW  = HCW + 1;   // full column index width
    localparam int RW  = HRW + 1;   // full row index width
    localparam int BAW = HRW + HCW; // bank address width
    localparam int IW  = (CW > RW) ? CW : RW;
    // coordinate width after sign extension, room for the bound compare
    localparam int PW  = ((CORD_W > FRAC_BITS + IW) ? CORD_W : FRAC_BITS + IW) + 1;
    // width for comparing the dimension registers against the maximums
    localparam int DW  = (IW + 1 > CFG_W) ? IW + 1 : CFG_W;

    // Configuration registers
    logic [CFG_W-1:0] r_cols;
    logic [CFG_W-1:0] r_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= CFG_DIM_RESET;
            r_rows <= CFG_DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COLS: r_cols <= i_cfg_data;
                CFG_ROWS: r_rows <= i_cfg_data;
            endcase
        end
    end

    // Handshake
    logic take_en;
    logic item_acc;
    logic query_acc;
    logic write_acc;

    assign i_item.ready = take_en;
    assign item_acc     = i_item.valid && take_en;
    assign query_acc    = item_acc && (i_item.mode == MODE_QUERY);
    assign write_acc    = item_acc && (i_item.mode == MODE_WRITE);

    // Effective dimensions: registers clamp to the built size.
    logic [DW-1:0] cols_eff, rows_eff;
    logic [DW-1:0] cols_m1, rows_m1;

    always_comb begin
        cols_eff = (DW'(r_cols) > DW'(MAX_COLS)) ? DW'(MAX_COLS) : DW'(r_cols);
        rows_eff = (DW'(r_rows) > DW'(MAX_ROWS)) ? DW'(MAX_ROWS) : DW'(r_rows);
        cols_m1  = cols_eff - DW'(1);
        rows_m1  = rows_eff - DW'(1);
    end

    // Query decode: bounds, integer cell, fraction, corner indexes.
    // Valid queries satisfy 0 <= x < (cols-1) << FRAC_BITS, so the integer
    // part and its right/lower neighbor both fit the index width.
    logic [PW-1:0]        x_ext, y_ext;
    logic [PW-1:0]        x_lim, y_lim;
    logic                 q_oob;
    logic [CW-1:0]        x0, x1;
    logic [RW-1:0]        y0, y1;
    logic [FRAC_BITS-1:0] fx, fy;
    t_qctl                qctl;

    always_comb begin
        x_ext = {{(PW - CORD_W){i_item.x_pos[CORD_W-1]}}, i_item.x_pos};
        y_ext = {{(PW - CORD_W){i_item.y_pos[CORD_W-1]}}, i_item.y_pos};
        x_lim = PW'(cols_m1) << FRAC_BITS;
        y_lim = PW'(rows_m1) << FRAC_BITS;
        q_oob = (cols_eff < DW'(2)) || (rows_eff < DW'(2)) ||
                x_ext[PW-1] || y_ext[PW-1] ||
                (x_ext >= x_lim) || (y_ext >= y_lim);
        x0 = x_ext[FRAC_BITS +: CW];
        y0 = y_ext[FRAC_BITS +: RW];
        x1 = x0 + CW'(1);
        y1 = y0 + RW'(1);
        fx = x_ext[FRAC_BITS-1:0];
        fy = y_ext[FRAC_BITS-1:0];
        qctl.oob = q_oob;
        qctl.px  = x0[0];
        qctl.py  = y0[0];
    end

    // Write decode: cells beyond the built grid are dropped.
    logic          wr_ok;
    logic [CW-1:0] wr_col;
    logic [RW-1:0] wr_row;

    always_comb begin
        wr_ok  = write_acc &&
                 (int'(i_item.cell_col) < MAX_COLS) &&
                 (int'(i_item.cell_row) < MAX_ROWS);
        wr_col = CW'(i_item.cell_col);
        wr_row = RW'(i_item.cell_row);
    end

    // Four parity banks. Bank index is {row parity, column parity}. Reads
    // and writes both happen at the accept edge, so a query always sees
    // every write accepted before it and none after it.
    logic [SAMPLE_W-1:0] corner [4];

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic RP = ((b / 2) == 1);
        localparam logic CP = ((b % 2) == 1);

        logic [CW-1:0]  col_sel;
        logic [RW-1:0]  row_sel;
        logic [BAW-1:0] raddr;
        logic [BAW-1:0] waddr;
        logic           we;

        always_comb begin
            // pick whichever of the two neighbors has this bank's parity
            col_sel = (x0[0] == CP) ? x0 : x1;
            row_sel = (y0[0] == RP) ? y0 : y1;
            raddr   = {row_sel[RW-1:1], col_sel[CW-1:1]};
            waddr   = {wr_row[RW-1:1], wr_col[CW-1:1]};
            we      = wr_ok && (wr_row[0] == RP) && (wr_col[0] == CP);
        end

        gbi_bank_ram #(
            .ADDR_W (BAW)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (waddr),
            .i_wdata (i_item.cell_value),
            .i_re    (query_acc),
            .i_raddr (raddr),
            .o_rdata (corner[b])
        );
    end

    // Blend pipeline and output register
    gbi_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (query_acc),
        .i_ctl     (qctl),
        .i_fx      (fx),
        .i_fy      (fy),
        .i_corner  (corner),
        .o_take_en (take_en),
        .o_result  (o_result)
    );

endmodule

// ===== tb/tb_grid_bilinear_interpolator.sv =====
// ----------------------------------------------------------------------------
// tb_grid_bilinear_interpolator: self-checking bench for the grid interpolator
// Drives cell writes and bilinear queries over several grid sizes, predicts
// every result beat in a scoreboard and compares elevation and status.
// ----------------------------------------------------------------------------
module tb_grid_bilinear_interpolator;
    timeunit 1ns;
    timeprecision 1ps;

    import gbi_pkg::*;

    // geometry and fixed-point format of the instance under test
    localparam int     GRID_DIM  = 256;
    localparam int     FRAC      = 8;
    localparam int     ONE       = 1 << FRAC;
    localparam longint ELEV_MAX  = 8388607;
    localparam longint ELEV_MIN  = -8388608;
    localparam longint VOID_ELEV = -9999 * ONE;   // marker for oob and void

    localparam int N_PHASES    = 12;
    localparam int PHASE_ITEMS = 160;
    localparam int HOLD_CYCLES = 400;    // long receiver hold-off
    localparam int DRAIN_PAUSE = 8;      // pipeline is 3 deep, writes give no beat
    localparam int TAIL_CYCLES = 20;
    localparam int WATCHDOG    = 4000;   // cycles without any accepted beat

    typedef struct {
        logic signed [ELEV_W-1:0] elevation;
        logic        [STAT_W-1:0] status;
    } t_elev_beat;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow grid, shadow dimension registers and the queue of
    // results still owed by the block.
    // ------------------------------------------------------------------------
    class interp_checker;
        logic signed [SAMPLE_W-1:0] grid [GRID_DIM*GRID_DIM];
        int                         cols_reg = GRID_DIM;
        int                         rows_reg = GRID_DIM;
        t_elev_beat                 owed_elev [$];
        int                         errors = 0;

        function void set_dims(int cols, int rows);
            cols_reg = cols;
            rows_reg = rows;
        endfunction

        function int pending();
            return owed_elev.size();
        endfunction

        // bilinear blend of the four corners around (x, y)
        function t_elev_beat blend_query(logic signed [CORD_W-1:0] x,
                                         logic signed [CORD_W-1:0] y);
            t_elev_beat res;
            int         cols, rows, x0, y0;
            longint     xs, ys, fx, fy, q00, q01, q10, q11, acc;
            cols = cols_reg > GRID_DIM ? GRID_DIM : cols_reg;
            rows = rows_reg > GRID_DIM ? GRID_DIM : rows_reg;
            xs   = longint'(x);
            ys   = longint'(y);
            res.status = ST_OK;
            // bounds come first, no corner is looked at for an oob query
            if (cols < 2 || rows < 2 || xs < 0 || ys < 0 ||
                xs >= longint'(cols - 1) * ONE || ys >= longint'(rows - 1) * ONE) begin
                res.status = ST_OOB;
                acc = VOID_ELEV;
            end else begin
                x0 = int'(xs >>> FRAC);
                y0 = int'(ys >>> FRAC);
                fx = xs & (ONE - 1);
                fy = ys & (ONE - 1);
                if (grid[y0*GRID_DIM + x0] == NO_DATA ||
                    grid[y0*GRID_DIM + x0 + 1] == NO_DATA ||
                    grid[(y0+1)*GRID_DIM + x0] == NO_DATA ||
                    grid[(y0+1)*GRID_DIM + x0 + 1] == NO_DATA) begin
                    res.status = ST_VOID;
                    acc = VOID_ELEV;
                end else begin
                    q00 = longint'(grid[y0*GRID_DIM + x0]);
                    q01 = longint'(grid[y0*GRID_DIM + x0 + 1]);
                    q10 = longint'(grid[(y0+1)*GRID_DIM + x0]);
                    q11 = longint'(grid[(y0+1)*GRID_DIM + x0 + 1]);
                    // exact sum, arithmetic shift floors toward minus infinity
                    acc = (q00 * (ONE - fx) * (ONE - fy) + q01 * fx * (ONE - fy) +
                           q10 * (ONE - fx) * fy + q11 * fx * fy) >>> FRAC;
                end
            end
            if (acc > ELEV_MAX) acc = ELEV_MAX;
            if (acc < ELEV_MIN) acc = ELEV_MIN;
            res.elevation = acc[ELEV_W-1:0];
            return res;
        endfunction

        function void note_item(logic mode, logic [CELL_W-1:0] col,
                                logic [CELL_W-1:0] row,
                                logic signed [SAMPLE_W-1:0] val,
                                logic signed [CORD_W-1:0] x,
                                logic signed [CORD_W-1:0] y);
            if (mode == MODE_WRITE)
                grid[int'(row)*GRID_DIM + int'(col)] = val;
            else
                owed_elev.push_back(blend_query(x, y));
        endfunction

        function void check_result(logic signed [ELEV_W-1:0] elev,
                                   logic [STAT_W-1:0] stat);
            t_elev_beat want;
            if (owed_elev.size() == 0) begin
                $error("result beat with no query waiting: elevation %0d, status %0d",
                       elev, stat);
                errors++;
                return;
            end
            want = owed_elev.pop_front();
            if (stat !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, stat);
                errors++;
            end
            if (elev !== want.elevation) begin
                $error("elevation: expected %0d, actual %0d", want.elevation, elev);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels, DUT
    // ------------------------------------------------------------------------
    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;

    gbi_item_if   item_ch ();
    gbi_result_if res_ch ();

    grid_bilinear_interpolator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_ch),
        .o_result   (res_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    interp_checker chk = new();

    // generator-side view: which cells hold data, and the clamped dimensions
    bit gen_written [GRID_DIM*GRID_DIM];
    int gen_cols = GRID_DIM;
    int gen_rows = GRID_DIM;
    bit idle_on  = 1'b1;    // random idling on both sides
    bit hold_req = 1'b0;    // asks the receiver for its one long hold-off
    int items_sent = 0;
    int quiet_cycles = 0;
    bit beat_seen;

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // filler for fields the mode does not use
    function automatic logic signed [CORD_W-1:0] junk_cord();
        return CORD_W'($urandom);
    endfunction

    function automatic logic [CELL_W-1:0] junk_cell();
        return CELL_W'($urandom);
    endfunction

    // sample for a cell: extremes and the no-data mark show up often
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 6)  return NO_DATA;
        if (roll < 12) return 16'sd32767;
        if (roll < 18) return -16'sd32767;
        return SAMPLE_W'($urandom);
    endfunction

    // coordinate along an axis with span cells between first and last line;
    // near_border picks the lines on either side of the bounds check
    function automatic logic signed [CORD_W-1:0] pick_coord(int span, bit near_border);
        if (span < 1) return CORD_W'($urandom);
        if (!near_border) return CORD_W'($urandom_range(0, span * ONE - 1));
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return CORD_W'(span * ONE - 1);
            2:       return CORD_W'(span * ONE);
            default: return CORD_W'(-1);
        endcase
    endfunction

    // one beat on the item channel; fields the mode does not use carry junk
    task automatic send_beat(input logic mode, input logic [CELL_W-1:0] col,
                             input logic [CELL_W-1:0] row,
                             input logic signed [SAMPLE_W-1:0] val,
                             input logic signed [CORD_W-1:0] x,
                             input logic signed [CORD_W-1:0] y);
        while (idle_on && $urandom_range(0, 99) < 13) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.mode       <= mode;
        item_ch.cell_col   <= col;
        item_ch.cell_row   <= row;
        item_ch.cell_value <= val;
        item_ch.x_pos      <= x;
        item_ch.y_pos      <= y;
        if (mode == MODE_WRITE)
            gen_written[int'(row)*GRID_DIM + int'(col)] = 1'b1;
        items_sent++;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
    endtask

    // query; an in-bounds query first gets its missing corners written, so
    // no cell is ever read before it holds data
    task automatic send_query(input logic signed [CORD_W-1:0] x,
                              input logic signed [CORD_W-1:0] y);
        int c0, r0;
        if (gen_cols >= 2 && gen_rows >= 2 && x >= 0 && y >= 0 &&
            x < (gen_cols - 1) * ONE && y < (gen_rows - 1) * ONE) begin
            c0 = int'(x >>> FRAC);
            r0 = int'(y >>> FRAC);
            for (int dr = 0; dr < 2; dr++)
                for (int dc = 0; dc < 2; dc++)
                    if (!gen_written[(r0 + dr)*GRID_DIM + c0 + dc])
                        send_beat(MODE_WRITE, CELL_W'(c0 + dc), CELL_W'(r0 + dr),
                                  pick_sample(), junk_cord(), junk_cord());
        end
        send_beat(MODE_QUERY, junk_cell(), junk_cell(), SAMPLE_W'($urandom), x, y);
    endtask

    // let the block go idle, then write both dimension registers
    task automatic write_dims(input int cols, input int rows);
        item_ch.valid <= 1'b0;
        while (chk.pending() != 0) @(posedge i_clk);
        // a trailing write leaves no beat behind, give the pipe time to settle
        repeat (DRAIN_PAUSE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_COLS;
        i_cfg_data <= CFG_W'(cols);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ROWS;
        i_cfg_data <= CFG_W'(rows);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        chk.set_dims(cols, rows);
        gen_cols = cols > GRID_DIM ? GRID_DIM : cols;
        gen_rows = rows > GRID_DIM ? GRID_DIM : rows;
    endtask

    // ------------------------------------------------------------------------
    // Sender: reset, directed beats, random phases, end of run
    // ------------------------------------------------------------------------
    initial begin
        int p, base, pick, cols, rows;
        logic [CELL_W-1:0] wc, wr;

        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_COLS;
        i_cfg_data         <= CFG_DIM_RESET;
        item_ch.valid      <= 1'b0;
        item_ch.mode       <= MODE_WRITE;
        item_ch.cell_col   <= '0;
        item_ch.cell_row   <= '0;
        item_ch.cell_value <= '0;
        item_ch.x_pos      <= '0;
        item_ch.y_pos      <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, reset dimensions 256 x 256
        // top-left patch at full positive scale
        send_beat(MODE_WRITE, 0, 0, 16'sd32767, junk_cord(), junk_cord());
        send_beat(MODE_WRITE, 1, 0, 16'sd32767, junk_cord(), junk_cord());
        send_beat(MODE_WRITE, 0, 1, 16'sd32767, junk_cord(), junk_cord());
        send_beat(MODE_WRITE, 1, 1, 16'sd32767, junk_cord(), junk_cord());
        send_query(255, 255);                   // largest fractions
        send_query(0, 0);                       // exactly on a corner
        // bottom-right patch, mixed signs
        send_beat(MODE_WRITE, 254, 254, -16'sd32767, junk_cord(), junk_cord());
        send_beat(MODE_WRITE, 255, 254, -16'sd1, junk_cord(), junk_cord());
        send_beat(MODE_WRITE, 254, 255, 16'sd0, junk_cord(), junk_cord());
        send_beat(MODE_WRITE, 255, 255, 16'sd12345, junk_cord(), junk_cord());
        send_query(17'sd65279, 17'sd65279);     // last point inside
        send_query(17'sd65281, 17'sd65283);     // just past the last column, out of bounds
        send_query(17'sd65280, 0);              // x on last column
        send_query(0, 17'sd65280);              // y on last row
        send_query(17'sd65535, 17'sd65535);
        send_query(-17'sd65536, -17'sd65536);
        send_query(-17'sd1, 17'sd128);
        // no-data corner
        send_beat(MODE_WRITE, 2, 0, NO_DATA, junk_cord(), junk_cord());
        send_beat(MODE_WRITE, 2, 1, -16'sd7, junk_cord(), junk_cord());
        send_query(17'sd384, 17'sd0);

        // random phases, each with its own grid size
        for (p = 0; p < N_PHASES; p++) begin
            case (p)
                0:       begin cols = 256; rows = 256; end
                1:       begin cols = 2;   rows = 2;   end
                2:       begin cols = 2;   rows = 256; end
                3:       begin cols = 256; rows = 2;   end
                4:       begin cols = 511; rows = 511; end   // clamps to the store
                5:       begin cols = 0;   rows = 1;   end   // every query oob
                6:       begin cols = 1;   rows = 300; end
                9:       begin cols = $urandom_range(0, 511); rows = $urandom_range(0, 511); end
                default: begin cols = $urandom_range(2, 24);  rows = $urandom_range(2, 24);  end
            endcase
            write_dims(cols, rows);
            idle_on = (p != 3);     // one phase runs flat out
            base = items_sent;
            while (items_sent - base < PHASE_ITEMS) begin
                if (p == 8 && items_sent - base >= 30) hold_req = 1'b1;
                pick = $urandom_range(0, 99);
                if (pick < 25) begin
                    // stray writes anywhere, or writes inside the grid in use
                    if ($urandom_range(0, 1)) begin
                        wc = junk_cell();
                        wr = junk_cell();
                    end else begin
                        wc = CELL_W'($urandom_range(0, gen_cols > 0 ? gen_cols - 1 : 0));
                        wr = CELL_W'($urandom_range(0, gen_rows > 0 ? gen_rows - 1 : 0));
                    end
                    send_beat(MODE_WRITE, wc, wr, pick_sample(), junk_cord(), junk_cord());
                end else if (pick < 70) begin
                    send_query(pick_coord(gen_cols - 1, 1'b0),
                               pick_coord(gen_rows - 1, 1'b0));
                end else if (pick < 82) begin
                    send_query(pick_coord(gen_cols - 1, 1'b1),
                               pick_coord(gen_rows - 1, 1'($urandom_range(0, 1))));
                end else begin
                    send_query(junk_cord(), junk_cord());
                end
            end
        end

        // drain, then a quiet tail that would catch any stray result beat
        item_ch.valid <= 1'b0;
        while (chk.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (chk.errors == 0 && chk.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        bit held;
        held = 1'b0;
        res_ch.ready <= 1'b0;
        forever begin
            if (hold_req && !held) begin
                // sender keeps offering, the block fills and stalls its input
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                held = 1'b1;
            end else begin
                res_ch.ready <= !(idle_on && $urandom_range(0, 99) < 13);
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor and watchdog: values read here are the ones at the edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            beat_seen = 1'b0;
            if (res_ch.valid && res_ch.ready) begin
                chk.check_result(res_ch.elevation, res_ch.status);
                beat_seen = 1'b1;
            end
            if (item_ch.valid && item_ch.ready) begin
                chk.note_item(item_ch.mode, item_ch.cell_col, item_ch.cell_row,
                              item_ch.cell_value, item_ch.x_pos, item_ch.y_pos);
                beat_seen = 1'b1;
            end
            quiet_cycles = beat_seen ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

endmodule
